[rtl/spn8_pkg.sv]
// shared types, register indexes and sizes for the spn8 counter-mode stream cipher
package spn8_pkg;

   localparam int unsigned RoundCount = 3;
   localparam int unsigned KeyCount   = RoundCount + 1;
   localparam int unsigned CsrIdxW    = 4;
   localparam int unsigned CsrDataW   = 64;

   typedef logic [7:0]             byte_type;
   typedef logic [8*KeyCount-1:0]  keys_type;
   typedef logic [63:0]            sbox_type;
   typedef logic [23:0]            perm_type;
   typedef logic [CsrIdxW-1:0]     csr_idx_type;
   typedef logic [CsrDataW-1:0]    csr_data_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROUND_KEYS      = 4'd0,
      CSR_SBOX_TABLE      = 4'd1,
      CSR_BIT_PERMUTATION = 4'd2,
      CSR_INITIAL_COUNTER = 4'd3
   } csr_reg_type;

   typedef struct packed {
      keys_type round_keys;
      sbox_type sbox_table;
      perm_type bit_permutation;
   } cipher_cfg_type;

endpackage

[rtl/spn8_ctr_stream_cipher.sv]
// top level of the spn8 counter-mode stream cipher: csr bank, counter, two-stage pipeline
// One beat in, one beat out. A request beat is registered together with its counter
// value (the IV when req_first_byte is set, otherwise the running counter), the
// three-round network and the data xor sit between that register and the output
// register, so the response becomes valid once the beat has moved on from that
// register into the output register, and the block takes a new beat every cycle
// while rsp_stall is low. The counter advances by one per accepted beat and wraps
// from 255 to 0; it starts at zero after reset. Encryption and decryption are the
// same operation. Registers are written through csr_wr_en, csr_index and csr_wdata;
// the user must write them only while no beat is in flight, and the block itself
// does not enforce this. Indexes above three are ignored.
module spn8_ctr_stream_cipher (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  spn8_pkg::csr_idx_type      csr_index,
   input  spn8_pkg::csr_data_type     csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  spn8_pkg::byte_type         req_data_in,
   input  logic                       req_first_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output spn8_pkg::byte_type         rsp_data_out
);

   spn8_pkg::keys_type  round_keys_ff;
   spn8_pkg::sbox_type  sbox_table_ff;
   spn8_pkg::perm_type  bit_permutation_ff;
   spn8_pkg::byte_type  initial_counter_ff;
   spn8_pkg::byte_type  counter_ff, counter_in;

   logic                s1_valid_ff, s1_valid_in;
   spn8_pkg::byte_type  s1_data_ff;
   spn8_pkg::byte_type  s1_ctr_ff, s1_ctr_in;
   logic                s2_valid_ff, s2_valid_in;
   spn8_pkg::byte_type  s2_data_ff, s2_data_in;

   spn8_pkg::cipher_cfg_type cfg;
   logic                req_accept;
   logic                s1_move;

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         round_keys_ff      <= '0;
         sbox_table_ff      <= '0;
         bit_permutation_ff <= '0;
         initial_counter_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (spn8_pkg::csr_reg_type'(csr_index))
            spn8_pkg::CSR_ROUND_KEYS:
               round_keys_ff <= csr_wdata[$bits(spn8_pkg::keys_type)-1:0];
            spn8_pkg::CSR_SBOX_TABLE:
               sbox_table_ff <= csr_wdata[$bits(spn8_pkg::sbox_type)-1:0];
            spn8_pkg::CSR_BIT_PERMUTATION:
               bit_permutation_ff <= csr_wdata[$bits(spn8_pkg::perm_type)-1:0];
            spn8_pkg::CSR_INITIAL_COUNTER:
               initial_counter_ff <= csr_wdata[$bits(spn8_pkg::byte_type)-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.round_keys      = round_keys_ff;
   assign cfg.sbox_table      = sbox_table_ff;
   assign cfg.bit_permutation = bit_permutation_ff;

   // pipeline flow
   assign s1_move    = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   assign s1_ctr_in   = req_first_byte ? initial_counter_ff : counter_ff;
   assign counter_in  = s1_ctr_in + 8'd1;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            counter_ff <= counter_in;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data_in;
         s1_ctr_ff  <= s1_ctr_in;
      end
      if (s1_move) begin
         s2_data_ff <= s2_data_in;
      end
   end

   spn8_cipher u_cipher (
      .ctr      (s1_ctr_ff),
      .data     (s1_data_ff),
      .cfg      (cfg),
      .data_out (s2_data_in)
   );

   assign rsp_valid    = s2_valid_ff;
   assign rsp_data_out = s2_data_ff;

   // checks
   a_first_loads_iv: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_first_byte |=> s1_ctr_ff == $past(initial_counter_ff)
         && counter_ff == s1_ctr_ff + 8'd1)
      else $error("first beat did not restart the counter from the iv");

   a_ctr_advances: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> counter_ff == s1_ctr_ff + 8'd1 && s1_valid_ff)
      else $error("counter did not advance with the accepted beat");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("request stalled while pipeline has room");

   a_beat_reaches_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid && rsp_data_out == $past(s2_data_in))
      else $error("network result lost on its way to the output");

endmodule

[rtl/spn8_round.sv]
// one network round: key xor, nibble s-box on both halves, bit permutation
module spn8_round (
   input  spn8_pkg::byte_type state_in,
   input  spn8_pkg::byte_type round_key,
   input  spn8_pkg::sbox_type sbox_table,
   input  spn8_pkg::perm_type bit_permutation,
   output spn8_pkg::byte_type state_out
);

   spn8_pkg::byte_type keyed;
   spn8_pkg::byte_type subst;

   assign keyed = state_in ^ round_key;

   always_comb begin
      subst[3:0] = sbox_table[{keyed[3:0], 2'b00} +: 4];
      subst[7:4] = sbox_table[{keyed[7:4], 2'b00} +: 4];
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         state_out[i] = subst[bit_permutation[3*i +: 3]];
      end
   end

endmodule

[rtl/spn8_cipher.sv]
// keystream network: three rounds and a closing key xor, then the data xor
module spn8_cipher (
   input  spn8_pkg::byte_type       ctr,
   input  spn8_pkg::byte_type       data,
   input  spn8_pkg::cipher_cfg_type cfg,
   output spn8_pkg::byte_type       data_out
);

   spn8_pkg::byte_type stage [spn8_pkg::RoundCount+1];

   assign stage[0] = ctr;

   for (genvar r = 0; r < spn8_pkg::RoundCount; r++) begin : g_round
      spn8_round u_round (
         .state_in        (stage[r]),
         .round_key       (cfg.round_keys[8*r +: 8]),
         .sbox_table      (cfg.sbox_table),
         .bit_permutation (cfg.bit_permutation),
         .state_out       (stage[r+1])
      );
   end

   assign data_out = data ^ stage[spn8_pkg::RoundCount]
                   ^ cfg.round_keys[8*spn8_pkg::RoundCount +: 8];

endmodule
